>>> hdl/rsfs_pkg.sv
// Shared constants, types and the sine table of the frame tone generator.
package rsfs_pkg;

  localparam int FRAMES = 64;
  localparam int FA     = $clog2(FRAMES);
  localparam int IW     = $clog2(FRAMES + 1);

  localparam logic [2:0] K_CLEAR = 3'd0;
  localparam logic [2:0] K_FRAME = 3'd1;
  localparam logic [2:0] K_END   = 3'd2;
  localparam logic [2:0] K_START = 3'd3;
  localparam logic [2:0] K_TICK  = 3'd4;

  localparam logic [31:0] PHASE_START = 32'd384 << 16;

  localparam logic [2:0] W_FULL    = 3'b001;
  localparam logic [2:0] W_NO_END  = 3'b010;
  localparam logic [2:0] W_NO_DATA = 3'b100;

  typedef struct packed {
    logic [15:0] dur;
    logic [7:0]  lvl;
    logic [31:0] lslope;
    logic [31:0] step;
    logic [15:0] sslope;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  localparam logic [7:0] SINE_Q [128] = '{
    8'd129, 8'd130, 8'd132, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140,
    8'd141, 8'd143, 8'd144, 8'd146, 8'd147, 8'd149, 8'd150, 8'd152,
    8'd154, 8'd155, 8'd157, 8'd158, 8'd160, 8'd161, 8'd163, 8'd164,
    8'd166, 8'd167, 8'd169, 8'd170, 8'd172, 8'd173, 8'd174, 8'd176,
    8'd177, 8'd179, 8'd180, 8'd182, 8'd183, 8'd184, 8'd186, 8'd187,
    8'd189, 8'd190, 8'd191, 8'd193, 8'd194, 8'd195, 8'd197, 8'd198,
    8'd199, 8'd200, 8'd202, 8'd203, 8'd204, 8'd206, 8'd207, 8'd208,
    8'd209, 8'd210, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217,
    8'd218, 8'd219, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226,
    8'd227, 8'd228, 8'd229, 8'd230, 8'd230, 8'd231, 8'd232, 8'd233,
    8'd234, 8'd235, 8'd236, 8'd237, 8'd237, 8'd238, 8'd239, 8'd240,
    8'd240, 8'd241, 8'd242, 8'd242, 8'd243, 8'd244, 8'd244, 8'd245,
    8'd246, 8'd246, 8'd247, 8'd247, 8'd248, 8'd248, 8'd249, 8'd249,
    8'd250, 8'd250, 8'd251, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252,
    8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

endpackage

>>> hdl/rsfs_if.sv
// Valid/ready channel interfaces for commands and results.
interface rsfs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] duration;
  logic [31:0] start_step;
  logic [31:0] end_step;
  logic [7:0]  start_level;
  logic [7:0]  end_level;
  modport source (output valid, kind, duration, start_step, end_step, start_level,
                  end_level, input ready);
  modport sink (input valid, kind, duration, start_step, end_step, start_level,
                end_level, output ready);
endinterface

interface rsfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] compare_value;
  logic [2:0] warning_bits;
  logic       playing;
  logic       finished;
  modport source (output valid, compare_value, warning_bits, playing, finished,
                  input ready);
  modport sink (input valid, compare_value, warning_bits, playing, finished,
                output ready);
endinterface

>>> hdl/rsfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsfs_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/rsfs_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
module rsfs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [31:0] quot
);
  logic [31:0] num_r;
  logic [15:0] den_r;
  logic [15:0] rem_r;
  logic [31:0] quot_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [16:0] sh;
  logic        fits;

  assign sh   = {rem_r, num_r[31]};
  assign fits = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= fits ? 16'(sh - {1'b0, den_r}) : sh[15:0];
      quot_r <= {quot_r[30:0], fits};
      num_r  <= {num_r[30:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

>>> hdl/ramped_sine_frame_synth.sv
// Top level: frame store, playback sequencer and sine output of the tone generator.
//
//  channel | dir | words
//  in_ch   | in  | command or sample tick (kind, duration, steps, levels)
//  out_ch  | out | one result word per command (compare value, warnings, state)
//
// Every accepted word gives exactly one result word; one word is in work at a time.
// Clear, end marker, zero-duration frame, start with warnings and a tick inside a
// frame go straight to the output state; start and a tick that loads the next frame
// read memory in S_RD and S_LOAD; a timed frame waits in S_DIV for the slope dividers.
// Reset is synchronous; the frame memories need no clearing pass.
// A stalled result holds the block in its output state until it is taken.
module ramped_sine_frame_synth (
  input  logic clk,
  input  logic rst_n,
  rsfs_in_if.sink    in_ch,
  rsfs_out_if.source out_ch
);
  import rsfs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r;
  logic [IW-1:0] wi_r, ri_r;
  logic [2:0]  warn_r;
  logic        active_r, last_nz_r, load_tick_r;
  logic [15:0] pulses_r;
  logic [31:0] level_r, step_r, phase_r, lsl_r;
  logic [15:0] ssl_r;
  logic [7:0]  cmp_r;
  logic        fin_r;

  logic [15:0] dur_r;
  logic [31:0] s0_r;
  logic [7:0]  l0_r;
  logic        lneg_r, sneg_r;

  logic        out_valid_r;
  logic [7:0]  out_cmp_r;
  logic [2:0]  out_warn_r;
  logic        out_play_r, out_fin_r;

  logic        we, we_body;
  logic [FA-1:0] waddr, raddr_r, raddr_nxt;
  frame_t      wdata, rdata;
  logic [15:0] rd_dur;
  logic [FRAME_W-17:0] rd_body;

  logic        accept;
  logic        div_start, div_done;
  logic [31:0] lnum, snum, lq, sq;
  logic [8:0]  ldiff;
  logic [31:0] sdiff;
  logic [31:0] lslope;
  logic [15:0] sslope;
  logic [2:0]  start_warn;

  logic [7:0]  p;
  logic [6:0]  tidx;
  logic [7:0]  s_raw, s_sign, s_fin;
  logic [15:0] prod;
  logic [7:0]  cmp_now;
  logic [15:0] pulses_dec;
  logic [IW-1:0] ri_inc;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Durations live apart from the rest so an end marker leaves the other fields alone.
  rsfs_ram #(.W(16), .D(FRAMES)) u_dur (
    .clk, .we, .waddr, .wdata(wdata.dur), .raddr(raddr_nxt), .rdata(rd_dur)
  );

  rsfs_ram #(.W(FRAME_W - 16), .D(FRAMES)) u_body (
    .clk, .we(we_body), .waddr, .wdata(wdata[FRAME_W-17:0]), .raddr(raddr_nxt),
    .rdata(rd_body)
  );

  assign rdata = {rd_dur, rd_body};

  // Level numerator is |end - start| << 16; step numerator is |end - start| as signed.
  assign ldiff = {1'b0, in_ch.end_level} - {1'b0, in_ch.start_level};
  assign lnum  = {8'd0, (ldiff[8] ? 8'(-ldiff) : ldiff[7:0]), 16'd0};
  assign sdiff = in_ch.end_step - in_ch.start_step;
  assign snum  = sdiff[31] ? -sdiff : sdiff;
  assign div_start = accept && (in_ch.kind == K_FRAME) && (wi_r < IW'(FRAMES))
                     && (in_ch.duration != 16'd0);

  rsfs_div u_ldiv (
    .clk, .rst_n, .start(div_start), .num(lnum), .den(in_ch.duration),
    .done(div_done), .quot(lq)
  );

  rsfs_div u_sdiv (
    .clk, .rst_n, .start(div_start), .num(snum), .den(in_ch.duration),
    .done(), .quot(sq)
  );

  always_comb begin
    lslope = lneg_r ? -lq : lq;
    if (sneg_r) begin
      sslope = (sq > 32'd32768) ? 16'h8000 : 16'(-sq);
    end else begin
      sslope = (sq > 32'd32767) ? 16'h7fff : sq[15:0];
    end
  end

  // Frame writes: divider completion, zero-duration frame or end marker at accept.
  always_comb begin
    we      = 1'b0;
    we_body = 1'b0;
    waddr   = wi_r[FA-1:0];
    wdata   = '{dur: dur_r, lvl: l0_r, lslope: lslope, step: s0_r, sslope: sslope};
    if (state_r == S_DIV && div_done) begin
      we      = 1'b1;
      we_body = 1'b1;
    end else if (accept && wi_r < IW'(FRAMES) &&
                 (in_ch.kind == K_END ||
                  (in_ch.kind == K_FRAME && in_ch.duration == 16'd0))) begin
      we      = 1'b1;
      we_body = (in_ch.kind == K_FRAME);
      wdata   = '{dur: 16'd0, lvl: in_ch.start_level, lslope: 32'd0,
                  step: in_ch.start_step, sslope: 16'd0};
    end
  end

  always_comb begin
    start_warn = warn_r;
    if (warn_r == 3'd0) begin
      if (wi_r != '0 && last_nz_r) start_warn = start_warn | W_NO_END;
      if (wi_r < IW'(2)) start_warn = start_warn | W_NO_DATA;
    end
  end

  // Sample path: quarter-wave lookup, half-wave fold, level scaling.
  always_comb begin
    p      = phase_r[23:16];
    tidx   = p[7] ? ~p[6:0] : p[6:0];
    s_raw  = SINE_Q[tidx];
    s_sign = phase_r[24] ? ~s_raw : s_raw;
    prod   = s_sign * level_r[23:16];
    s_fin  = (level_r[31:24] == 8'd0) ? prod[15:8] : s_sign;
    cmp_now = 8'd128 - {1'b0, s_fin[7:1]};
  end

  assign pulses_dec = pulses_r - 16'd1;
  assign ri_inc     = ri_r + IW'(1);

  always_comb begin
    raddr_nxt = raddr_r;
    if (accept && in_ch.kind == K_START) begin
      raddr_nxt = '0;
    end else if (accept && in_ch.kind == K_TICK) begin
      raddr_nxt = ri_inc[FA-1:0];
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    if (accept) begin
      dur_r  <= in_ch.duration;
      s0_r   <= in_ch.start_step;
      l0_r   <= in_ch.start_level;
      lneg_r <= ldiff[8];
      sneg_r <= sdiff[31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wi_r        <= '0;
      ri_r        <= '0;
      warn_r      <= '0;
      active_r    <= 1'b0;
      last_nz_r   <= 1'b0;
      load_tick_r <= 1'b0;
      pulses_r    <= '0;
      level_r     <= '0;
      step_r      <= '0;
      phase_r     <= PHASE_START;
      out_valid_r <= 1'b0;
      cmp_r       <= '0;
      fin_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmp_r   <= '0;
            fin_r   <= 1'b0;
            state_r <= S_OUT;
            case (in_ch.kind) inside
              K_CLEAR: begin
                wi_r     <= '0;
                warn_r   <= '0;
                active_r <= 1'b0;
              end
              K_FRAME, K_END: begin
                if (wi_r >= IW'(FRAMES)) begin
                  warn_r <= warn_r | W_FULL;
                end else if (div_start) begin
                  state_r <= S_DIV;
                end else begin
                  wi_r      <= wi_r + IW'(1);
                  last_nz_r <= 1'b0;
                end
              end
              K_START: begin
                warn_r <= start_warn;
                if (start_warn != 3'd0) begin
                  active_r <= 1'b0;
                end else begin
                  load_tick_r <= 1'b0;
                  state_r     <= S_RD;
                end
              end
              K_TICK: begin
                if (active_r) begin
                  cmp_r    <= cmp_now;
                  phase_r  <= phase_r + step_r;
                  pulses_r <= pulses_dec;
                  if (pulses_dec != 16'd0) begin
                    level_r <= level_r + lsl_r;
                    step_r  <= step_r + {{16{ssl_r[15]}}, ssl_r};
                  end else begin
                    ri_r <= ri_inc;
                    if (ri_inc < wi_r) begin
                      load_tick_r <= 1'b1;
                      state_r     <= S_RD;
                    end else begin
                      active_r <= 1'b0;
                      fin_r    <= 1'b1;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            wi_r      <= wi_r + IW'(1);
            last_nz_r <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_RD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r  <= S_OUT;
          pulses_r <= rdata.dur;
          if (load_tick_r && rdata.dur == 16'd0) begin
            active_r <= 1'b0;
            fin_r    <= 1'b1;
          end else begin
            level_r <= {7'd0, 9'({1'b0, rdata.lvl} + 9'd1), 16'd0};
            step_r  <= rdata.step;
            if (!load_tick_r) begin
              active_r <= 1'b1;
              ri_r     <= '0;
              phase_r  <= PHASE_START;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Current frame slopes are kept in registers so a tick needs no memory read.
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      lsl_r <= rdata.lslope;
      ssl_r <= rdata.sslope;
    end
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_cmp_r  <= cmp_r;
      out_warn_r <= warn_r;
      out_play_r <= active_r;
      out_fin_r  <= fin_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.compare_value = out_cmp_r;
  assign out_ch.warning_bits  = out_warn_r;
  assign out_ch.playing       = out_play_r;
  assign out_ch.finished      = out_fin_r;
endmodule
